FILE: sv/twg_pkg.sv
// -----------------------------------------------------------------------------
// twg_pkg
// Shared types and constants for the test waveform generator.
// -----------------------------------------------------------------------------
package twg_pkg;

  // Waveform select codes.
  localparam logic [1:0] WAVE_SILENCE = 2'd0;
  localparam logic [1:0] WAVE_RAMP    = 2'd1;
  localparam logic [1:0] WAVE_SINE    = 2'd2;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_WAVEFORM      = 3'd0,
    REG_RAMP_PERIOD   = 3'd1,
    REG_PHASE_STEP    = 3'd2,
    REG_GAIN          = 3'd3,
    REG_CHANNEL_COUNT = 3'd4
  } twg_reg_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMUL,
    ST_RLOAD,
    ST_RDIV,
    ST_SMUL,
    ST_SRND,
    ST_EMIT
  } twg_state_e;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned TAB_W     = 15;
  localparam int unsigned DIVN_W    = 33;
  localparam int unsigned DIVQ_W    = 16;
  localparam int unsigned DIVCNT_W  = 5;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] dividend;
    logic [DIVQ_W-1:0] divisor;
  } twg_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVQ_W-1:0] quotient;
  } twg_div_rsp_t;

endpackage

FILE: sv/test_waveform_generator.sv
// -----------------------------------------------------------------------------
// test_waveform_generator
// Silence, ramp and sine test signal source with interleaved channel output.
// -----------------------------------------------------------------------------
// Usage:
//   Each input beat with frame_request_i high asks for one frame. The block
//   computes one signed sample and sends it as channel_count output beats,
//   channel_index_o counting from 0 and last_in_frame_o set on the final one.
//   A beat with frame_request_i low is taken and produces nothing.
//   in_stall_o is high while a frame is being computed or sent; one frame is
//   in flight at a time. The receiver may hold out_stall_i as long as it
//   likes; the current beat then holds and the block simply waits.
//   For silence the first output beat comes in the cycle after the input beat.
//   Sine goes through table read, multiply and round before its first beat, and
//   the ramp through a multiply, a divider load and the 16-step serial divider.
//   The further channel beats follow back to back while out_stall_i is low, and
//   the block then returns to idle, where it can take the next frame request.
//   The configuration channel is always ready; writes are meant for idle
//   periods and any write to a known register restarts both phase counters.
//   Reset loads the register defaults (silence, period 1, step 0, unity gain,
//   one channel) and clears both phases. No clearing pass is needed.
module test_waveform_generator #(
  parameter int unsigned MAX_CHANNELS    = 8,
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned PHASE_BITS      = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Frame request channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               frame_request_i,
  // Sample channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] sample_o,
  output logic [2:0]         channel_index_o,
  output logic               last_in_frame_o,
  // Configuration write channel.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import twg_pkg::*;

  localparam int unsigned MUL_A_W = 31;
  localparam int unsigned MUL_P_W = 47;

  // Configuration registers.
  logic [1:0]  waveform_q;
  logic [15:0] ramp_period_q;
  logic [31:0] phase_step_q;
  logic [15:0] gain_q;
  logic [3:0]  channel_count_q;

  // Phase state.
  logic [15:0]           ramp_phase_q, ramp_phase_d;
  logic [PHASE_BITS-1:0] sine_phase_q, sine_phase_d;

  twg_state_e state_q, state_d;

  logic        in_accept;
  logic        req;
  logic        out_accept;
  logic        cfg_write;
  logic        cfg_known;
  logic [15:0] per;
  logic [15:0] perm1;
  logic [16:0] two_p;
  logic [16:0] ramp_mag;
  logic        ramp_neg;
  logic [3:0]  nch;

  // Frame working registers (payload, no reset).
  logic [15:0]        mag_q;
  logic               neg_q;
  logic [MUL_P_W-1:0] prod_q;
  logic [15:0]        sample_q, sample_d;
  logic               sample_we;
  logic [3:0]         nch_q;
  logic [3:0]         ch_q;

  // Shared multiplier.
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_P_W-1:0] mul_p;

  logic [47:0] ramp_num;
  logic [16:0] sine_rnd;
  logic        last_beat;

  twg_div_req_t div_req;
  twg_div_rsp_t div_rsp;
  logic [TAB_W-1:0] rom_data;

  // Saturate a sign and magnitude pair to a 16-bit two's complement sample.
  function automatic logic [15:0] sat16(input logic neg, input logic [16:0] mag);
    logic [15:0] r;
    if (neg) begin
      r = (mag > 17'd32768) ? 16'h8000 : 16'(17'd0 - mag);
    end else begin
      r = (mag > 17'd32767) ? 16'h7FFF : mag[15:0];
    end
    return r;
  endfunction

  assign in_accept  = in_valid_i && !in_stall_o;
  assign req        = in_accept && frame_request_i;
  assign out_accept = out_valid_o && !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_write  = cfg_valid_i && cfg_ready_o;

  always_comb begin
    case (cfg_index_i)
      REG_WAVEFORM, REG_RAMP_PERIOD, REG_PHASE_STEP, REG_GAIN, REG_CHANNEL_COUNT:
        cfg_known = 1'b1;
      default:
        cfg_known = 1'b0;
    endcase
  end

  // A period of zero behaves like one.
  assign per   = (ramp_period_q == 16'd0) ? 16'd1 : ramp_period_q;
  assign perm1 = per - 16'd1;

  // Distance of 2p from the ramp center (P - 1) and its side.
  always_comb begin
    two_p = {ramp_phase_q, 1'b0};
    if (two_p >= {1'b0, perm1}) begin
      ramp_mag = two_p - {1'b0, perm1};
      ramp_neg = 1'b0;
    end else begin
      ramp_mag = {1'b0, perm1} - two_p;
      ramp_neg = 1'b1;
    end
  end

  // Channel count: zero acts as one, large values saturate.
  always_comb begin
    if (channel_count_q == 4'd0) begin
      nch = 4'd1;
    end else if (int'(channel_count_q) > int'(MAX_CHANNELS)) begin
      nch = 4'(MAX_CHANNELS);
    end else begin
      nch = channel_count_q;
    end
  end

  // Phase advance on each frame.
  always_comb begin
    ramp_phase_d = ((17'(ramp_phase_q) + 17'd1) >= 17'(per)) ? 16'd0 : ramp_phase_q + 16'd1;
    sine_phase_d = sine_phase_q + PHASE_BITS'(phase_step_q);
  end

  twg_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk_i  (clk_i),
    .rd_en_i(req),
    .idx_i  (sine_phase_q[PHASE_BITS-1 -: SINE_TABLE_BITS]),
    .rdata_o(rom_data)
  );

  twg_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Multiplier operand select: ramp uses mag * 32767, sine uses the table.
  always_comb begin
    if (state_q == ST_RMUL) begin
      mul_a = {mag_q, 15'd0} - {15'd0, mag_q};
    end else begin
      mul_a = {16'd0, rom_data};
    end
    mul_p = MUL_P_W'(mul_a) * MUL_P_W'(gain_q);
  end

  // Ramp numerator: (mag*32767*gain + (P-1)*16384) >> 15 feeds the divider.
  assign ramp_num = {1'b0, prod_q} + {18'd0, perm1, 14'd0};
  assign sine_rnd = 17'((prod_q + MUL_P_W'(16384)) >> 15);

  assign div_req.start    = (state_q == ST_RLOAD);
  assign div_req.dividend = ramp_num[47:15];
  assign div_req.divisor  = perm1;

  assign last_beat = (ch_q == (nch_q - 4'd1));

  // Sequencer: next state and sample update.
  always_comb begin
    state_d   = state_q;
    sample_d  = sample_q;
    sample_we = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (req) begin
          if (waveform_q == WAVE_RAMP && perm1 != 16'd0) begin
            state_d = ST_RMUL;
          end else if (waveform_q == WAVE_SINE) begin
            state_d = ST_SMUL;
          end else begin
            sample_d  = '0;
            sample_we = 1'b1;
            state_d   = ST_EMIT;
          end
        end
      end
      ST_RMUL:  state_d = ST_RLOAD;
      ST_RLOAD: state_d = ST_RDIV;
      ST_RDIV: begin
        if (div_rsp.done) begin
          sample_d  = sat16(neg_q, {1'b0, div_rsp.quotient});
          sample_we = 1'b1;
          state_d   = ST_EMIT;
        end
      end
      ST_SMUL: state_d = ST_SRND;
      ST_SRND: begin
        sample_d  = sat16(neg_q, sine_rnd);
        sample_we = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_accept && last_beat) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration and phase registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q      <= WAVE_SILENCE;
      ramp_period_q   <= 16'd1;
      phase_step_q    <= '0;
      gain_q          <= 16'd32768;
      channel_count_q <= 4'd1;
      ramp_phase_q    <= '0;
      sine_phase_q    <= '0;
      ch_q            <= '0;
    end else begin
      if (cfg_write) begin
        unique case (twg_reg_e'(cfg_index_i))
          REG_WAVEFORM:      waveform_q      <= cfg_data_i[1:0];
          REG_RAMP_PERIOD:   ramp_period_q   <= cfg_data_i[15:0];
          REG_PHASE_STEP:    phase_step_q    <= cfg_data_i;
          REG_GAIN:          gain_q          <= cfg_data_i[15:0];
          REG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (cfg_write && cfg_known) begin
        ramp_phase_q <= '0;
        sine_phase_q <= '0;
      end else if (req) begin
        ramp_phase_q <= ramp_phase_d;
        sine_phase_q <= sine_phase_d;
      end
      if (req) begin
        ch_q <= '0;
      end else if (out_accept) begin
        ch_q <= ch_q + 4'd1;
      end
    end
  end

  // Frame working registers.
  always_ff @(posedge clk_i) begin
    if (req) begin
      mag_q <= ramp_mag[15:0];
      nch_q <= nch;
      // Sine sign comes from the upper quadrant bit.
      neg_q <= (waveform_q == WAVE_SINE) ? sine_phase_q[PHASE_BITS-1] : ramp_neg;
    end
    if (state_q == ST_RMUL || state_q == ST_SMUL) begin
      prod_q <= mul_p;
    end
    if (sample_we) begin
      sample_q <= sample_d;
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = (state_q == ST_EMIT);
  assign sample_o        = $signed(sample_q);
  assign channel_index_o = ch_q[2:0];
  assign last_in_frame_o = last_beat;

`ifndef SYNTHESIS
  // Output beats only leave while the block holds off new requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("output beat while input side is open");

  // A frame always starts at channel zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (channel_index_o == 3'd0))
    else $error("frame does not start at channel zero");

  // The final beat of a frame ends the output burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_in_frame_o) |=> !out_valid_o)
    else $error("output continues after last beat of frame");

  // An empty request leaves the block ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !frame_request_i) |=> !in_stall_o)
    else $error("empty request made the block busy");
`endif

endmodule

FILE: sv/twg_div.sv
// -----------------------------------------------------------------------------
// twg_div
// Radix-2 restoring divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
// The dividend must be below divisor * 2^16, so the quotient fits in 16 bits
// and the initial remainder is its upper part.
module twg_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  twg_pkg::twg_div_req_t req_i,
  output twg_pkg::twg_div_rsp_t rsp_o
);
  import twg_pkg::*;

  logic [DIVQ_W-1:0]   rem_q, rem_d;
  logic [DIVQ_W-1:0]   quo_q, quo_d;
  logic [DIVQ_W-1:0]   dvs_q;
  logic [DIVCNT_W-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DIVQ_W:0]     trial;
  logic [DIVQ_W:0]     diff;
  logic                fits;

  always_comb begin
    trial  = {rem_q, quo_q[DIVQ_W-1]};
    diff   = trial - {1'b0, dvs_q};
    fits   = (trial >= {1'b0, dvs_q});
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.dividend[DIVN_W-2:DIVQ_W];
      quo_d  = req_i.dividend[DIVQ_W-1:0];
      cnt_d  = DIVCNT_W'(DIVQ_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIVQ_W-1:0] : trial[DIVQ_W-1:0];
      quo_d = {quo_q[DIVQ_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIVCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: sv/twg_sine_rom.sv
// -----------------------------------------------------------------------------
// twg_sine_rom
// Quarter-wave sine table with registered read and quadrant folding.
// -----------------------------------------------------------------------------
// The table holds round(32767 * sin(k * pi / (2 * Q))) for k = 0..Q. It is
// built at elaboration from a fixed-point Taylor series.
module twg_sine_rom #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                             clk_i,
  input  logic                             rd_en_i,
  input  logic [SINE_TABLE_BITS-1:0]       idx_i,
  output logic [twg_pkg::TAB_W-1:0]        rdata_o
);
  import twg_pkg::*;

  localparam int unsigned QBITS  = SINE_TABLE_BITS - 2;
  localparam int unsigned QLEN   = 1 << QBITS;
  localparam int unsigned ADDR_W = QBITS + 1;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  function automatic logic [(QLEN+1)*TAB_W-1:0] build_qtab();
    logic [(QLEN+1)*TAB_W-1:0] t;
    logic [127:0] w;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [63:0]  v;
    t = '0;
    for (int k = 0; k <= int'(QLEN); k++) begin
      w  = 128'(HALF_PI_Q62) * 128'(k);
      x  = 64'(w >> QBITS);
      w  = 128'(x) * 128'(x);
      x2 = 64'(w >> 62);
      term = x;
      sum  = x;
      for (int n = 1; n <= 13; n++) begin
        w    = 128'(term) * 128'(x2);
        term = 64'(w >> 62) / 64'((2 * n) * (2 * n + 1));
        if ((n & 1) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = ((sum >> 22) * 64'd32767 + (64'd1 << 39)) >> 40;
      if (v > 64'd32767 || k == int'(QLEN)) begin
        v = 64'd32767;
      end
      t[k*TAB_W +: TAB_W] = v[TAB_W-1:0];
    end
    return t;
  endfunction

  localparam logic [(QLEN+1)*TAB_W-1:0] QTAB = build_qtab();

  logic [QBITS-1:0]  off;
  logic [ADDR_W-1:0] addr;
  logic [TAB_W-1:0]  rdata_q;

  // Odd quadrants read the table backwards.
  always_comb begin
    off  = idx_i[QBITS-1:0];
    addr = idx_i[QBITS] ? (ADDR_W'(QLEN) - {1'b0, off}) : {1'b0, off};
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= QTAB[addr*TAB_W +: TAB_W];
    end
  end

  assign rdata_o = rdata_q;

endmodule
